@@ rtl/key_led_heat_decay_defines.svh @@
// ----------------------------------------------------------------------------
// key_led_heat_decay_defines.svh
// Assertion macros used by the checker file of the key heat map block.
// ----------------------------------------------------------------------------
`ifndef KEY_LED_HEAT_DECAY_DEFINES_SVH
`define KEY_LED_HEAT_DECAY_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define KLHD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key heat map check failed");

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define KLHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key heat map check failed");

`endif

@@ rtl/klhd_pkg.sv @@
// ----------------------------------------------------------------------------
// klhd_pkg
// Types and constants shared by the modules of the key heat map block.
// ----------------------------------------------------------------------------
`default_nettype none

package klhd_pkg;

    localparam int KEY_IDX_W = 6;
    localparam int CHAN_W    = 8;
    localparam int COLOUR_W  = 3 * CHAN_W;
    localparam int IDLE_W    = 9;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic [CHAN_W-1:0] idle_delay;
        logic [CHAN_W-1:0] default_red;
        logic [CHAN_W-1:0] default_green;
        logic [CHAN_W-1:0] default_blue;
        logic [2:0]        heat_mask;
        logic [CHAN_W-1:0] heat_step;
        logic [CHAN_W-1:0] cool_step;
    } cfg_t;

    // One classified request waiting for the back part.
    typedef struct packed {
        logic                 cool;
        logic [KEY_IDX_W-1:0] key;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/klhd_ram.sv @@
// ----------------------------------------------------------------------------
// klhd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module klhd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 36,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/klhd_front.sv @@
// ----------------------------------------------------------------------------
// klhd_front
// Accepts requests, maps characters to keys, and keeps the idle tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module klhd_front #(
    parameter int NUM_KEYS = 36
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          operation,
    input  wire logic [7:0]                    char_code,
    input  wire logic [klhd_pkg::CHAN_W-1:0]   idle_delay,
    input  wire logic                          full,
    output logic                               busy,
    output logic                               push,
    output klhd_pkg::cmd_t                     push_data
);

    localparam logic       OP_CHAR  = 1'b0;
    localparam logic       OP_TICK  = 1'b1;
    localparam logic [7:0] CHAR_D0  = 8'h30;
    localparam logic [7:0] CHAR_D9  = 8'h39;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UZ  = 8'h5A;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LZ  = 8'h7A;
    localparam logic [7:0] LETTER_BASE = 8'd10;
    localparam logic [klhd_pkg::KEY_IDX_W:0] KEY_LIMIT = (klhd_pkg::KEY_IDX_W + 1)'(NUM_KEYS);
    localparam logic [klhd_pkg::IDLE_W-1:0]  IDLE_MAX  = '1;

    logic [klhd_pkg::IDLE_W-1:0]    idle_reg;
    logic [klhd_pkg::IDLE_W-1:0]    idle_next;
    logic [klhd_pkg::IDLE_W-1:0]    idle_inc;
    logic                           accept;
    logic                           is_char;
    logic [7:0]                     raw_key;
    logic [klhd_pkg::KEY_IDX_W-1:0] key;
    logic                           key_ok;
    logic                           cool_go;

    assign busy   = full;
    assign accept = start && !full;

    // Map the character to a key; anything else is not a key.
    always_comb
    begin
        is_char = 1'b1;
        raw_key = 8'd0;
        if (char_code >= CHAR_D0 && char_code <= CHAR_D9)
        begin
            raw_key = char_code - CHAR_D0;
        end
        else if (char_code >= CHAR_UA && char_code <= CHAR_UZ)
        begin
            raw_key = char_code - CHAR_UA + LETTER_BASE;
        end
        else if (char_code >= CHAR_LA && char_code <= CHAR_LZ)
        begin
            raw_key = char_code - CHAR_LA + LETTER_BASE;
        end
        else
        begin
            is_char = 1'b0;
        end
    end

    assign key    = raw_key[klhd_pkg::KEY_IDX_W-1:0];
    assign key_ok = is_char && ({1'b0, key} < KEY_LIMIT);

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign cool_go  = idle_inc > {1'b0, idle_delay};

    always_comb
    begin
        idle_next      = idle_reg;
        push           = 1'b0;
        push_data.cool = (operation == OP_TICK);
        push_data.key  = key;
        if (accept)
        begin
            if (operation == OP_TICK)
            begin
                idle_next = idle_inc;
                push      = cool_go;
            end
            else if (operation == OP_CHAR && key_ok)
            begin
                idle_next = '0;
                push      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= '0;
        end
        else
        begin
            idle_reg <= idle_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/klhd_queue.sv @@
// ----------------------------------------------------------------------------
// klhd_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module klhd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  klhd_pkg::cmd_t      push_data,
    input  wire logic           pop,
    output klhd_pkg::cmd_t      pop_data,
    output logic                empty,
    output logic                full
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    klhd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    head_next;
    logic [PW-1:0]    tail_reg;
    logic [PW-1:0]    tail_next;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PW + 1)'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[head_reg];

    always_comb
    begin
        head_next  = do_pop ? head_reg + 1'b1 : head_reg;
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/klhd_back.sv @@
// ----------------------------------------------------------------------------
// klhd_back
// Carries out heat and cool requests on the colour memory and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module klhd_back #(
    parameter int NUM_KEYS = 36
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  klhd_pkg::cfg_t                           cfg,
    input  klhd_pkg::cmd_t                           cmd,
    input  wire logic                                empty,
    output logic                                     pop,
    output logic                                     strobe,
    output logic [klhd_pkg::KEY_IDX_W-1:0]           key_index,
    output logic [klhd_pkg::CHAN_W-1:0]              red,
    output logic [klhd_pkg::CHAN_W-1:0]              green,
    output logic [klhd_pkg::CHAN_W-1:0]              blue,
    output logic                                     last_of_run
);

    localparam int          KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(NUM_KEYS - 1);
    localparam logic        S_IDLE   = 1'b0;
    localparam logic        S_RUN    = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [KEY_AW-1:0]                  cur_key_reg;
    logic [KEY_AW-1:0]                  cur_key_next;
    logic                               cur_cool_reg;
    logic                               cur_cool_next;
    logic [NUM_KEYS-1:0]                valid_reg;
    logic                               rd_valid_reg;
    logic [KEY_AW-1:0]                  rd_addr;
    logic [klhd_pkg::COLOUR_W-1:0]      rdata;
    logic [klhd_pkg::COLOUR_W-1:0]      old_colour;
    logic [klhd_pkg::COLOUR_W-1:0]      new_colour;
    logic                               we;
    logic                               last_key;
    logic                               strobe_reg;
    logic [klhd_pkg::KEY_IDX_W-1:0]     key_index_reg;
    logic [klhd_pkg::COLOUR_W-1:0]      colour_reg;
    logic                               last_reg;

    function automatic logic [7:0] heat_chan(input logic [7:0] v, input logic drop,
                                             input logic raise, input logic [7:0] step);
        logic [7:0] low;
        logic [8:0] sum;
        low = drop ? ((v > step) ? v - step : 8'd0) : v;
        sum = {1'b0, low} + {1'b0, step};
        if (raise)
        begin
            heat_chan = sum[8] ? 8'hFF : sum[7:0];
        end
        else
        begin
            heat_chan = low;
        end
    endfunction

    function automatic logic [7:0] cool_chan(input logic [7:0] v, input logic [7:0] d,
                                             input logic [7:0] step);
        logic [8:0] up;
        logic [8:0] lim;
        up  = {1'b0, v} + {1'b0, step};
        lim = {1'b0, d} + {1'b0, step};
        if (v <= d)
        begin
            cool_chan = (up > {1'b0, d}) ? d : up[7:0];
        end
        else
        begin
            cool_chan = ({1'b0, v} < lim) ? d : v - step;
        end
    endfunction

    klhd_ram #(
        .WIDTH (klhd_pkg::COLOUR_W),
        .DEPTH (NUM_KEYS)
    ) u_klhd_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cur_key_reg),
        .wdata (new_colour),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign last_key   = (cur_key_reg == LAST_KEY);
    assign we         = (state_reg == S_RUN);
    // An entry never written since reset reads as zero through its valid bit.
    assign old_colour = rd_valid_reg ? rdata : '0;

    always_comb
    begin
        if (cur_cool_reg)
        begin
            new_colour = {cool_chan(old_colour[23:16], cfg.default_red,   cfg.cool_step),
                          cool_chan(old_colour[15:8],  cfg.default_green, cfg.cool_step),
                          cool_chan(old_colour[7:0],   cfg.default_blue,  cfg.cool_step)};
        end
        else
        begin
            new_colour = {heat_chan(old_colour[23:16], cfg.default_red != 8'd0,
                                    cfg.heat_mask[2], cfg.heat_step),
                          heat_chan(old_colour[15:8], cfg.default_green != 8'd0,
                                    cfg.heat_mask[1], cfg.heat_step),
                          heat_chan(old_colour[7:0], cfg.default_blue != 8'd0,
                                    cfg.heat_mask[0], cfg.heat_step)};
        end
    end

    // The read for the next key is issued while the current key is written.
    always_comb
    begin
        state_next    = state_reg;
        cur_key_next  = cur_key_reg;
        cur_cool_next = cur_cool_reg;
        rd_addr       = cur_key_reg;
        pop           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop           = 1'b1;
                    state_next    = S_RUN;
                    cur_cool_next = cmd.cool;
                    cur_key_next  = cmd.cool ? '0 : cmd.key[KEY_AW-1:0];
                    rd_addr       = cur_key_next;
                end
            end
            S_RUN:
            begin
                if (cur_cool_reg && !last_key)
                begin
                    cur_key_next = cur_key_reg + 1'b1;
                    rd_addr      = cur_key_next;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_index_reg <= klhd_pkg::KEY_IDX_W'(cur_key_reg);
        colour_reg    <= new_colour;
        last_reg      <= !cur_cool_reg || last_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_key_reg  <= '0;
            cur_cool_reg <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_key_reg  <= cur_key_next;
            cur_cool_reg <= cur_cool_next;
            rd_valid_reg <= valid_reg[rd_addr];
            strobe_reg   <= we;
            if (we)
            begin
                valid_reg[cur_key_reg] <= 1'b1;
            end
        end
    end

    assign strobe      = strobe_reg;
    assign key_index   = key_index_reg;
    assign red         = colour_reg[23:16];
    assign green       = colour_reg[15:8];
    assign blue        = colour_reg[7:0];
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ rtl/key_led_heat_decay.sv @@
// ----------------------------------------------------------------------------
// key_led_heat_decay
// Per-key RGB heat map: key presses heat a key, idle ticks cool all keys.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// With operation low, char_code names a key ('0'-'9', 'A'-'Z', 'a'-'z');
// any other byte is dropped without a result. With operation high, the
// request is one idle tick; once the idle count exceeds idle_delay, every
// key moves one cool_step toward the default colour and is reported.
// Results appear for one cycle each, marked by strobe; last_of_run flags
// the final report of a request. The receiver cannot stall the block.
// A key press gives its single result after the queue, the colour memory read
// and the result registers. A cooling tick takes the same path and reports
// keys 0 to NUM_KEYS-1 in consecutive cycles, one colour memory read and
// write per key per cycle, once the idle state has popped it and started
// the sweep. Up to two requests wait in a queue; busy is high while it is
// full. Reset clears the idle count, the queue and the per-key valid bits,
// so all keys read back as zero, and loads the register defaults. The user
// must write registers over the APB port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module key_led_heat_decay #(
    parameter int NUM_KEYS = 36
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Request channel.
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            operation,
    input  wire logic [7:0]                      char_code,
    // Result channel.
    output logic                                 strobe,
    output logic [klhd_pkg::KEY_IDX_W-1:0]       key_index,
    output logic [klhd_pkg::CHAN_W-1:0]          red,
    output logic [klhd_pkg::CHAN_W-1:0]          green,
    output logic [klhd_pkg::CHAN_W-1:0]          blue,
    output logic                                 last_of_run,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [4:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Register indexes; register i lives at byte address 4*i.
    localparam logic [2:0] REG_IDLE_DELAY    = 3'd0;
    localparam logic [2:0] REG_DEFAULT_RED   = 3'd1;
    localparam logic [2:0] REG_DEFAULT_GREEN = 3'd2;
    localparam logic [2:0] REG_DEFAULT_BLUE  = 3'd3;
    localparam logic [2:0] REG_HEAT_MASK     = 3'd4;
    localparam logic [2:0] REG_HEAT_STEP     = 3'd5;
    localparam logic [2:0] REG_COOL_STEP     = 3'd6;

    klhd_pkg::cfg_t cfg_reg;
    klhd_pkg::cmd_t push_data;
    klhd_pkg::cmd_t pop_data;
    logic           cfg_write;
    logic [2:0]     reg_index;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file. A write to an index past the list has no effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_delay    <= 8'd2;
            cfg_reg.default_red   <= 8'd0;
            cfg_reg.default_green <= 8'd0;
            cfg_reg.default_blue  <= 8'd0;
            cfg_reg.heat_mask     <= 3'd4;
            cfg_reg.heat_step     <= 8'd16;
            cfg_reg.cool_step     <= 8'd4;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_IDLE_DELAY:    cfg_reg.idle_delay    <= pwdata[7:0];
                REG_DEFAULT_RED:   cfg_reg.default_red   <= pwdata[7:0];
                REG_DEFAULT_GREEN: cfg_reg.default_green <= pwdata[7:0];
                REG_DEFAULT_BLUE:  cfg_reg.default_blue  <= pwdata[7:0];
                REG_HEAT_MASK:     cfg_reg.heat_mask     <= pwdata[2:0];
                REG_HEAT_STEP:     cfg_reg.heat_step     <= pwdata[7:0];
                REG_COOL_STEP:     cfg_reg.cool_step     <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Read data is returned combinationally during the access cycle.
    always_comb
    begin
        case (reg_index)
            REG_IDLE_DELAY:    prdata = {24'd0, cfg_reg.idle_delay};
            REG_DEFAULT_RED:   prdata = {24'd0, cfg_reg.default_red};
            REG_DEFAULT_GREEN: prdata = {24'd0, cfg_reg.default_green};
            REG_DEFAULT_BLUE:  prdata = {24'd0, cfg_reg.default_blue};
            REG_HEAT_MASK:     prdata = {29'd0, cfg_reg.heat_mask};
            REG_HEAT_STEP:     prdata = {24'd0, cfg_reg.heat_step};
            REG_COOL_STEP:     prdata = {24'd0, cfg_reg.cool_step};
            default:           prdata = 32'd0;
        endcase
    end

    // The front classifies each request and tracks idle time; only requests
    // that produce results reach the queue.
    klhd_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_klhd_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .char_code  (char_code),
        .idle_delay (cfg_reg.idle_delay),
        .full       (full),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    klhd_queue u_klhd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty),
        .full      (full)
    );

    // The back side owns the colour memory and the result registers.
    klhd_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_klhd_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (pop_data),
        .empty       (empty),
        .pop         (pop),
        .strobe      (strobe),
        .key_index   (key_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/klhd_checker.sv @@
// ----------------------------------------------------------------------------
// klhd_checker
// Port-level checks on the result stream of the key heat map block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_led_heat_decay_defines.svh"

module klhd_checker #(
    parameter int NUM_KEYS = 36
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       strobe,
    input wire logic [5:0] key_index,
    input wire logic       last_of_run
);

    localparam logic [5:0] LAST_KEY = 6'(NUM_KEYS - 1);

    // Reported keys stay inside the key range.
    `KLHD_ASSERT_IMPL(a_key_range, strobe, key_index <= LAST_KEY)
    // A burst of several reports is a cooling sweep and begins at key 0.
    `KLHD_ASSERT_IMPL(a_sweep_start, $rose(strobe) && !last_of_run, key_index == 6'd0)
    // Within a sweep, reports come in back-to-back cycles with rising keys.
    `KLHD_ASSERT_NEXT(a_sweep_step, strobe && !last_of_run,
                      strobe && key_index == $past(key_index) + 6'd1)
    // The last report of a request is followed by a quiet cycle.
    `KLHD_ASSERT_NEXT(a_run_gap, strobe && last_of_run, !strobe)

endmodule

bind key_led_heat_decay klhd_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_klhd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .strobe      (strobe),
    .key_index   (key_index),
    .last_of_run (last_of_run)
);

`default_nettype wire
